// ===== design/positional_list_engine_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the positional list engine
// Shared check forms used by the RTL: same-cycle and next-cycle implication.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLST_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("positional list engine check failed");

// The consequent must hold in the cycle after the antecedent.
`define PLST_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("positional list engine check failed");

`endif

// ===== design/plst_pkg.sv =====
// ----------------------------------------------------------------------------
// Positional list engine package
// Field widths, request and status codes, cell control and state types.
// ----------------------------------------------------------------------------
package plst_pkg;

    localparam int REQ_W       = 2;
    localparam int POS_W       = 16;
    localparam int VALUE_W     = 32;
    localparam int DATA_W      = 31;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 9;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 40;
    localparam int OR_GROUP    = 16;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT  = 2'd0,
        REQ_DELETE  = 2'd1,
        REQ_REPLACE = 2'd2,
        REQ_CLEAR   = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE         = 2'd0,
        ST_NOT_POSITIVE = 2'd1,
        ST_BAD_POSITION = 2'd2,
        ST_FULL         = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_WRITE  = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] wdata;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_GATHER = 2'd1,
        S_MERGE  = 2'd2,
        S_APPLY  = 2'd3
    } t_state;

endpackage

// ===== design/positional_list_engine_top.sv =====
// ----------------------------------------------------------------------------
// Positional list engine
// Ordered list of positive values with insert, delete, replace and clear.
// ----------------------------------------------------------------------------
// Each request goes from acceptance to a result in the output register
// through the states idle (accept and check), gather and merge (read the
// addressed entry back through a two-level registered OR tree over the row
// of cells) and apply (every cell shifts or loads at once and the count is
// updated). The request port is closed until apply completes, and apply
// waits while a previous result is still held. The store needs no clearing
// pass after reset; only entries below the count are ever read.
// ----------------------------------------------------------------------------
`include "positional_list_engine_top_assert.svh"

module positional_list_engine_top #(
    parameter int CAPACITY = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // position [15:0], value [47:16]
    input  logic [plst_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // req_type [1:0]
    input  logic [plst_pkg::REQ_W-1:0]      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // old_value [30:0], count_after [39:31]
    output logic [plst_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // status [1:0]
    output logic [plst_pkg::STATUS_W-1:0]   m_axis_tuser
);
    import plst_pkg::*;

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CW > POS_W) ? CW + 1 : POS_W + 1;
    localparam int N1    = (CAPACITY + OR_GROUP - 1) / OR_GROUP;
    localparam int N2    = (N1 + OR_GROUP - 1) / OR_GROUP;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    t_state              r_state;
    t_state              n_state;
    t_req                r_req;
    logic [POS_W-1:0]    r_pos;
    logic [DATA_W-1:0]   r_wdata;
    t_status             r_status;
    t_status             n_status;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                r_out_valid;
    t_status             r_out_status;
    logic [DATA_W-1:0]   r_out_old;
    logic [COUNT_OUT_W-1:0] r_out_count;

    logic                w_accept;
    logic                w_out_free;
    logic                w_gather_en;
    logic                w_merge_en;
    logic                w_apply;
    t_req                w_req;
    logic [POS_W-1:0]    w_pos;
    logic [VALUE_W-1:0]  w_value;
    logic                w_positive;
    logic [CMP_W-1:0]    w_pos_c;
    logic [CMP_W-1:0]    w_cnt_c;
    logic [DATA_W-1:0]   w_old;
    logic [CW+COUNT_OUT_W-1:0] w_cnt_wide;
    t_cell_ctl           w_ctl;

    logic [DATA_W-1:0]   w_cell_value [CAPACITY];
    logic [DATA_W-1:0]   w_cell_hit   [CAPACITY];
    logic [DATA_W-1:0]   w_lvl1       [N1];
    logic [DATA_W-1:0]   w_lvl2       [N2];

    // Request decode and checks against the current count.
    assign w_req      = t_req'(s_axis_tuser);
    assign w_pos      = s_axis_tdata[POS_W-1:0];
    assign w_value    = s_axis_tdata[POS_W+VALUE_W-1:POS_W];
    assign w_positive = (w_value != '0) && !w_value[VALUE_W-1];
    assign w_pos_c    = CMP_W'(w_pos);
    assign w_cnt_c    = CMP_W'(r_count);

    always_comb begin
        n_status = ST_DONE;
        case (w_req)
            REQ_INSERT: begin
                if (!w_positive) begin
                    n_status = ST_NOT_POSITIVE;
                end else if (w_pos_c > w_cnt_c) begin
                    n_status = ST_BAD_POSITION;
                end else if (r_count == CAP_C) begin
                    n_status = ST_FULL;
                end
            end
            REQ_DELETE: begin
                if (w_pos_c >= w_cnt_c) begin
                    n_status = ST_BAD_POSITION;
                end
            end
            REQ_REPLACE: begin
                if (!w_positive) begin
                    n_status = ST_NOT_POSITIVE;
                end else if (w_pos_c >= w_cnt_c) begin
                    n_status = ST_BAD_POSITION;
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    // Sequencer.
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_accept   = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_GATHER;
                end
            end
            S_GATHER: begin
                n_state = S_MERGE;
            end
            S_MERGE: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        w_gather_en   = 1'b0;
        w_merge_en    = 1'b0;
        w_apply       = 1'b0;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
            end
            S_GATHER: begin
                w_gather_en = 1'b1;
            end
            S_MERGE: begin
                w_merge_en = 1'b1;
            end
            S_APPLY: begin
                w_apply = w_out_free;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req    <= w_req;
            r_pos    <= w_pos;
            r_wdata  <= w_value[DATA_W-1:0];
            r_status <= n_status;
        end
    end

    // Broadcast control for the row of cells.
    always_comb begin
        w_ctl.pos   = r_pos;
        w_ctl.wdata = r_wdata;
        w_ctl.op    = CELL_HOLD;
        if (w_apply && (r_status == ST_DONE)) begin
            case (r_req)
                REQ_INSERT:  w_ctl.op = CELL_INSERT;
                REQ_DELETE:  w_ctl.op = CELL_DELETE;
                REQ_REPLACE: w_ctl.op = CELL_WRITE;
                default:     w_ctl.op = CELL_HOLD;
            endcase
        end
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;
        if (i == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_inner_l
            assign w_left = w_cell_value[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner_r
            assign w_right = w_cell_value[i+1];
        end
        plst_cell #(
            .IDX (i)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_left      (w_left),
            .i_right     (w_right),
            .o_value     (w_cell_value[i]),
            .o_hit_value (w_cell_hit[i])
        );
    end

    // Read-back of the addressed entry before the row changes.
    plst_or_stage #(
        .N_IN (CAPACITY)
    ) u_or_lvl1 (
        .i_clk  (i_clk),
        .i_en   (w_gather_en),
        .i_data (w_cell_hit),
        .o_data (w_lvl1)
    );

    plst_or_stage #(
        .N_IN (N1)
    ) u_or_lvl2 (
        .i_clk  (i_clk),
        .i_en   (w_merge_en),
        .i_data (w_lvl1),
        .o_data (w_lvl2)
    );

    always_comb begin
        w_old = '0;
        for (int k = 0; k < N2; k++) begin
            w_old = w_old | w_lvl2[k];
        end
    end

    // Count update.
    always_comb begin
        n_count = r_count;
        case (r_req)
            REQ_INSERT: begin
                if (r_status == ST_DONE) begin
                    n_count = r_count + CW'(1);
                end
            end
            REQ_DELETE: begin
                if (r_status == ST_DONE) begin
                    n_count = r_count - CW'(1);
                end
            end
            REQ_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    assign w_cnt_wide = {{COUNT_OUT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_apply) begin
            r_count <= n_count;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_apply) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_apply) begin
            r_out_status <= r_status;
            r_out_count  <= w_cnt_wide[COUNT_OUT_W-1:0];
            if ((r_status == ST_DONE) && ((r_req == REQ_DELETE) || (r_req == REQ_REPLACE))) begin
                r_out_old <= w_old;
            end else begin
                r_out_old <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {r_out_count, r_out_old};

    `PLST_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CAP_C)
    `PLST_ASSERT_NEXT(a_apply_shows_result, i_clk, i_rst_n, w_apply, m_axis_tvalid)
    `PLST_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n,
        w_apply && (r_req == REQ_INSERT) && (r_status == ST_DONE),
        r_count == $past(r_count) + CW'(1))
    `PLST_ASSERT_SAME(a_reject_no_old, i_clk, i_rst_n,
        m_axis_tvalid && (r_out_status != ST_DONE), r_out_old == '0)

endmodule

// ===== design/plst_cell.sv =====
// ----------------------------------------------------------------------------
// List cell
// Holds one list entry and shifts, loads or keeps it under broadcast control.
// ----------------------------------------------------------------------------
module plst_cell #(
    parameter int IDX = 0
) (
    input  logic                        i_clk,
    input  plst_pkg::t_cell_ctl         i_ctl,
    input  logic [plst_pkg::DATA_W-1:0] i_left,
    input  logic [plst_pkg::DATA_W-1:0] i_right,
    output logic [plst_pkg::DATA_W-1:0] o_value,
    output logic [plst_pkg::DATA_W-1:0] o_hit_value
);
    import plst_pkg::*;

    localparam logic [POS_W-1:0] IDX_P = POS_W'(IDX);

    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] n_value;
    logic              w_hit;
    logic              w_above;

    assign w_hit   = (i_ctl.pos == IDX_P);
    assign w_above = (i_ctl.pos < IDX_P);

    always_comb begin
        n_value = r_value;
        case (i_ctl.op)
            CELL_INSERT: begin
                if (w_hit) begin
                    n_value = i_ctl.wdata;
                end else if (w_above) begin
                    n_value = i_left;
                end
            end
            CELL_DELETE: begin
                if (w_hit || w_above) begin
                    n_value = i_right;
                end
            end
            CELL_WRITE: begin
                if (w_hit) begin
                    n_value = i_ctl.wdata;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value     = r_value;
    assign o_hit_value = w_hit ? r_value : '0;

endmodule

// ===== design/plst_or_stage.sv =====
// ----------------------------------------------------------------------------
// Read-back OR stage
// Registered OR reduction of its inputs in groups of sixteen.
// ----------------------------------------------------------------------------
module plst_or_stage #(
    parameter int N_IN = 16,
    localparam int N_OUT = (N_IN + plst_pkg::OR_GROUP - 1) / plst_pkg::OR_GROUP
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [plst_pkg::DATA_W-1:0] i_data [N_IN],
    output logic [plst_pkg::DATA_W-1:0] o_data [N_OUT]
);
    import plst_pkg::*;

    logic [DATA_W-1:0] r_data [N_OUT];
    logic [DATA_W-1:0] n_data [N_OUT];

    always_comb begin
        for (int g = 0; g < N_OUT; g++) begin
            n_data[g] = '0;
            for (int k = 0; k < OR_GROUP; k++) begin
                if (g * OR_GROUP + k < N_IN) begin
                    n_data[g] = n_data[g] | i_data[g * OR_GROUP + k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Positional list engine testbench
// Drives insert, delete, replace and clear requests through the request
// stream, starting with a table of directed cases and then random phases
// that grow, shrink, fill and scramble the list. A local copy of the list
// gives the expected status, old value and count where a directed row gives
// none, and each returned transaction is compared against them in order.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import plst_pkg::*;

    localparam int LIST_CAP     = 256;
    localparam int RANDOM_ITEMS = 500;

    typedef enum int {
        MODE_MIX    = 0,
        MODE_GROW   = 1,
        MODE_SHRINK = 2,
        MODE_NOISE  = 3
    } t_gen_mode;

    typedef struct packed {
        t_req                kind;
        logic [POS_W-1:0]    pos;
        logic [VALUE_W-1:0]  value;
    } t_list_req;

    typedef struct packed {
        t_status                 status;
        logic [DATA_W-1:0]       old_value;
        logic [COUNT_OUT_W-1:0]  count_after;
    } t_list_result;

    typedef struct packed {
        t_list_req     rq;
        logic          typed;
        t_list_result  res;
    } t_directed_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic [REQ_W-1:0]       s_axis_tuser = REQ_INSERT;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic [STATUS_W-1:0]    m_axis_tuser;

    logic [DATA_W-1:0]  list_store [LIST_CAP];
    int                 list_len = 0;
    t_list_result       pending_results [$];
    int                 mismatch_count = 0;
    int                 sent_items = 0;
    int                 burst_left = 0;
    int                 rx_cycle = 0;
    int                 rx_mode = 0;

    t_directed_row directed_rows [24] = '{
        '{'{REQ_DELETE,  16'd0,      32'd0},        1'b1, '{ST_BAD_POSITION, 31'd0, 9'd0}},
        '{'{REQ_REPLACE, 16'd0,      32'd5},        1'b1, '{ST_BAD_POSITION, 31'd0, 9'd0}},
        '{'{REQ_INSERT,  16'd0,      32'd0},        1'b1, '{ST_NOT_POSITIVE, 31'd0, 9'd0}},
        '{'{REQ_INSERT,  16'd0,      32'hFFFFFFFF}, 1'b1, '{ST_NOT_POSITIVE, 31'd0, 9'd0}},
        '{'{REQ_INSERT,  16'd0,      32'h80000000}, 1'b1, '{ST_NOT_POSITIVE, 31'd0, 9'd0}},
        '{'{REQ_INSERT,  16'd1,      32'd7},        1'b1, '{ST_BAD_POSITION, 31'd0, 9'd0}},
        '{'{REQ_INSERT,  16'hFFFF,   32'h7FFFFFFF}, 1'b1, '{ST_BAD_POSITION, 31'd0, 9'd0}},
        '{'{REQ_INSERT,  16'd0,      32'h7FFFFFFF}, 1'b1, '{ST_DONE,         31'd0, 9'd1}},
        '{'{REQ_INSERT,  16'd0,      32'd1},        1'b1, '{ST_DONE,         31'd0, 9'd2}},
        '{'{REQ_INSERT,  16'd2,      32'h2AAAAAAA}, 1'b1, '{ST_DONE,         31'd0, 9'd3}},
        '{'{REQ_INSERT,  16'd1,      32'h55555555}, 1'b1, '{ST_DONE,         31'd0, 9'd4}},
        '{'{REQ_REPLACE, 16'd2,      32'd0},        1'b1, '{ST_NOT_POSITIVE, 31'd0, 9'd4}},
        '{'{REQ_REPLACE, 16'd4,      32'd9},        1'b1, '{ST_BAD_POSITION, 31'd0, 9'd4}},
        '{'{REQ_REPLACE, 16'hFFFF,   32'hFFFFFFFF}, 1'b1, '{ST_NOT_POSITIVE, 31'd0, 9'd4}},
        '{'{REQ_REPLACE, 16'd2,      32'd3},        1'b0, '{ST_DONE,         31'd0, 9'd0}},
        '{'{REQ_DELETE,  16'd4,      32'hFFFFFFFF}, 1'b1, '{ST_BAD_POSITION, 31'd0, 9'd4}},
        '{'{REQ_DELETE,  16'd0,      32'd0},        1'b0, '{ST_DONE,         31'd0, 9'd0}},
        '{'{REQ_DELETE,  16'd2,      32'h7FFFFFFF}, 1'b0, '{ST_DONE,         31'd0, 9'd0}},
        '{'{REQ_INSERT,  16'd2,      32'h12345678}, 1'b0, '{ST_DONE,         31'd0, 9'd0}},
        '{'{REQ_CLEAR,   16'hFFFF,   32'h80000000}, 1'b1, '{ST_DONE,         31'd0, 9'd0}},
        '{'{REQ_DELETE,  16'd0,      32'd0},        1'b1, '{ST_BAD_POSITION, 31'd0, 9'd0}},
        '{'{REQ_CLEAR,   16'd0,      32'd0},        1'b1, '{ST_DONE,         31'd0, 9'd0}},
        '{'{REQ_INSERT,  16'd0,      32'h40000000}, 1'b1, '{ST_DONE,         31'd0, 9'd1}},
        '{'{REQ_DELETE,  16'd0,      32'h7FFFFFFF}, 1'b0, '{ST_DONE,         31'd0, 9'd0}}
    };

    positional_list_engine_top #(
        .CAPACITY(LIST_CAP)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    task automatic apply_list_request(input t_list_req rq, output t_list_result res);
        logic positive;
        int   p;
        positive = (rq.value != '0) && !rq.value[VALUE_W-1];
        p = int'(rq.pos);
        res.status = ST_DONE;
        res.old_value = '0;
        case (rq.kind)
            REQ_INSERT: begin
                if (!positive) begin
                    res.status = ST_NOT_POSITIVE;
                end else if (p > list_len) begin
                    res.status = ST_BAD_POSITION;
                end else if (list_len >= LIST_CAP) begin
                    res.status = ST_FULL;
                end else begin
                    for (int i = list_len; i > p; i--) list_store[i] = list_store[i-1];
                    list_store[p] = rq.value[DATA_W-1:0];
                    list_len++;
                end
            end
            REQ_DELETE: begin
                if (p >= list_len) begin
                    res.status = ST_BAD_POSITION;
                end else begin
                    res.old_value = list_store[p];
                    for (int i = p; i + 1 < list_len; i++) list_store[i] = list_store[i+1];
                    list_len--;
                end
            end
            REQ_REPLACE: begin
                if (!positive) begin
                    res.status = ST_NOT_POSITIVE;
                end else if (p >= list_len) begin
                    res.status = ST_BAD_POSITION;
                end else begin
                    res.old_value = list_store[p];
                    list_store[p] = rq.value[DATA_W-1:0];
                end
            end
            default: begin
                list_len = 0;
            end
        endcase
        res.count_after = list_len[COUNT_OUT_W-1:0];
    endtask

    function automatic logic [VALUE_W-1:0] rand_positive();
        int                 roll;
        logic [VALUE_W-1:0] v;
        roll = $urandom_range(0, 99);
        if (roll < 20) begin
            v = $urandom_range(1, 16);
        end else if (roll < 25) begin
            v = 32'h7FFFFFFF;
        end else begin
            v = $urandom() & 32'h7FFFFFFF;
            if (v == '0) v = 32'd1;
        end
        return v;
    endfunction

    function automatic t_list_req next_request(input t_gen_mode mode);
        t_list_req rq;
        int        roll;
        int        ins_w;
        int        del_w;
        int        rep_w;
        roll = $urandom_range(0, 99);
        if (mode == MODE_NOISE) begin
            rq.kind = t_req'($urandom_range(0, 3));
            rq.value = $urandom();
            if (roll < 50) rq.pos = 16'($urandom_range(0, list_len + 1));
            else rq.pos = 16'($urandom());
            return rq;
        end
        case (mode)
            MODE_GROW:   begin ins_w = 75; del_w = 10; rep_w = 14; end
            MODE_SHRINK: begin ins_w = 15; del_w = 70; rep_w = 14; end
            default:     begin ins_w = 40; del_w = 30; rep_w = 28; end
        endcase
        if (roll < ins_w) rq.kind = REQ_INSERT;
        else if (roll < ins_w + del_w) rq.kind = REQ_DELETE;
        else if (roll < ins_w + del_w + rep_w) rq.kind = REQ_REPLACE;
        else rq.kind = REQ_CLEAR;

        roll = $urandom_range(0, 99);
        if (roll < 5) begin
            rq.pos = 16'(list_len + ((rq.kind == REQ_INSERT) ? 1 : 0)
                         + $urandom_range(0, 2));
        end else if (roll < 10) begin
            rq.pos = 16'($urandom());
        end else if (rq.kind == REQ_INSERT) begin
            rq.pos = 16'($urandom_range(0, list_len));
        end else if (list_len > 0) begin
            rq.pos = 16'($urandom_range(0, list_len - 1));
        end else begin
            rq.pos = '0;
        end

        roll = $urandom_range(0, 99);
        if (roll < 2) rq.value = '0;
        else if (roll < 5) rq.value = {1'b1, 31'($urandom())};
        else rq.value = rand_positive();
        return rq;
    endfunction

    task automatic send_request(input t_list_req rq, input logic typed,
                                input t_list_result typed_res);
        t_list_result res;
        int           gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rq.value, rq.pos};
        s_axis_tuser  <= rq.kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        apply_list_request(rq, res);
        pending_results.push_back(typed ? typed_res : res);
        sent_items++;
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 48 == 0) rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= ($urandom_range(0, 4) == 0);
            default: m_axis_tready <= rx_cycle[2];
        endcase
    end

    always @(posedge i_clk) begin : result_check
        t_list_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result: status %0d old %0d count %0d", $time,
                         m_axis_tuser, m_axis_tdata[30:0], m_axis_tdata[39:31]);
            end else begin
                want = pending_results.pop_front();
                if (want.status !== m_axis_tuser || want.old_value !== m_axis_tdata[30:0]
                        || want.count_after !== m_axis_tdata[39:31]) begin
                    mismatch_count++;
                    $display("%0t: mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                             $time, want.status, want.old_value, want.count_after,
                             m_axis_tuser, m_axis_tdata[30:0], m_axis_tdata[39:31]);
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        t_list_req    rq;
        t_list_result none;
        t_gen_mode    mode;
        int           phase;
        int           len;
        none = '{ST_DONE, 31'd0, 9'd0};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].res);
        end
        wait_results_drained();

        sent_items = 0;
        phase = 0;
        while (sent_items < RANDOM_ITEMS) begin
            if (phase == 3) begin
                while (list_len < LIST_CAP) begin
                    rq = '{REQ_INSERT, 16'($urandom_range(0, list_len)), rand_positive()};
                    send_request(rq, 1'b0, none);
                end
                send_request('{REQ_INSERT, 16'(LIST_CAP), rand_positive()}, 1'b0, none);
                send_request('{REQ_INSERT, 16'd0, 32'h7FFFFFFF}, 1'b0, none);
                send_request('{REQ_INSERT, 16'(LIST_CAP + 1), rand_positive()}, 1'b0, none);
                send_request('{REQ_INSERT, 16'd0, 32'd0}, 1'b0, none);
                send_request('{REQ_REPLACE, 16'(LIST_CAP - 1), rand_positive()}, 1'b0, none);
                send_request('{REQ_DELETE, 16'(LIST_CAP), 32'($urandom())}, 1'b0, none);
                send_request('{REQ_DELETE, 16'(LIST_CAP - 1), 32'($urandom())}, 1'b0, none);
                send_request('{REQ_INSERT, 16'(LIST_CAP - 1), rand_positive()}, 1'b0, none);
                send_request('{REQ_CLEAR, 16'($urandom()), 32'($urandom())}, 1'b0, none);
            end else begin
                mode = t_gen_mode'($urandom_range(0, 3));
                if (phase == 0) mode = MODE_GROW;
                len = $urandom_range(20, 60);
                repeat (len) send_request(next_request(mode), 1'b0, none);
            end
            wait_results_drained();
            phase++;
        end

        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
